### sv/sfbe_pkg.sv
// Shared types, opcodes and constants of the syscall filter bytecode engine.
`default_nettype none
package sfbe_pkg;

  localparam int PROG_DEPTH_DEF = 256;
  localparam int LEN_W          = 9;
  localparam int PC_W           = 10;
  localparam int SLOT_W         = 8;
  localparam int WORD_W         = 32;
  localparam int REC_W          = 512;
  localparam int LOAD_MAX       = 60;

  localparam logic [15:0] OP_LDW  = 16'h0020;
  localparam logic [15:0] OP_JEQ  = 16'h0015;
  localparam logic [15:0] OP_JGE  = 16'h0035;
  localparam logic [15:0] OP_JGT  = 16'h0025;
  localparam logic [15:0] OP_JSET = 16'h0045;
  localparam logic [15:0] OP_RET  = 16'h0006;

  typedef struct packed {
    logic [15:0]       opcode;
    logic [7:0]        jt;
    logic [7:0]        jf;
    logic [WORD_W-1:0] k;
  } insn_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EXEC,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

### sv/syscall_filter_bytecode_engine.sv
// Top level of the syscall filter bytecode engine: ports, length register, result register.
`default_nettype none
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+------------------------------------------
//  in_      | input     | in_valid/in_ready  | mode, slot, instruction, syscall record
//  out_     | output    | out_valid/out_ready| verdict (one per evaluate transfer)
//  cfg_     | input     | cfg_we             | program_length (9 bits)
//
// A write transfer stores one instruction and the engine is ready again at once. An
// evaluate transfer runs the program: each instruction is fetched from the program store
// (registered read data) in FETCH and then executed in EXEC, until a return or a fault
// ends the run or a fetch finds the program counter at or past the end of the program;
// DONE then hands the verdict to the output register. Reset is synchronous and active low;
// it clears the sequencer, the output valid flag and program_length, but not the program
// store, whose entries are undefined until written. A stalled output holds the verdict in
// the output register while the next transfer is accepted; a second verdict waits in the
// sequencer until it drains.
module syscall_filter_bytecode_engine #(
  parameter int PROG_DEPTH = sfbe_pkg::PROG_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic [7:0]  in_slot,
  input  wire logic [63:0] in_instruction,
  input  wire logic [31:0] in_syscall_number,
  input  wire logic [31:0] in_arch_id,
  input  wire logic [63:0] in_arg0,
  input  wire logic [63:0] in_arg1,
  input  wire logic [63:0] in_arg2,
  input  wire logic [63:0] in_arg3,
  input  wire logic [63:0] in_arg4,
  input  wire logic [63:0] in_arg5,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_verdict,
  input  wire logic        cfg_we,
  input  wire logic [8:0]  cfg_wdata
);

  logic [sfbe_pkg::LEN_W-1:0]  program_length_r;
  logic [sfbe_pkg::PC_W-1:0]   limit;
  logic [sfbe_pkg::REC_W-1:0]  record;
  logic                        res_valid, res_ready;
  logic [sfbe_pkg::WORD_W-1:0] res_verdict;
  logic                        out_valid_r;
  logic [sfbe_pkg::WORD_W-1:0] out_verdict_r;

  // The record is little endian: syscall number, arch, eight zero bytes, then six arguments.
  assign record = {in_arg5, in_arg4, in_arg3, in_arg2, in_arg1, in_arg0, 64'd0,
                   in_arch_id, in_syscall_number};

  // A length beyond the store depth is clipped to the depth.
  assign limit = (32'(program_length_r) > PROG_DEPTH) ? sfbe_pkg::PC_W'(PROG_DEPTH)
                                                      : sfbe_pkg::PC_W'(program_length_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      program_length_r <= '0;
    end else if (cfg_we) begin
      program_length_r <= cfg_wdata;
    end
  end

  sfbe_core #(.PROG_DEPTH(PROG_DEPTH)) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_slot        (in_slot),
    .in_instruction (in_instruction),
    .in_record      (record),
    .limit          (limit),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .res_verdict    (res_verdict)
  );

  // The output register takes a new verdict when empty or being emptied in this cycle.
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_verdict_r <= res_verdict;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_verdict = out_verdict_r;

  // A write transfer never leaves the engine busy.
  a_write_stays_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_mode) |=> in_ready)
    else $error("engine busy after a write transfer");

  // An evaluate transfer always starts a run.
  a_eval_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_mode) |=> !in_ready)
    else $error("evaluate transfer did not start a run");

  // A verdict handed over always appears at the output.
  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> out_valid)
    else $error("verdict lost between sequencer and output register");

  // The sequencer never offers a verdict while idle.
  a_idle_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !res_valid)
    else $error("verdict offered while idle");

endmodule
`default_nettype wire

### sv/sfbe_store.sv
// Program store: one write port, one read port with registered read data.
`default_nettype none
module sfbe_store #(
  parameter int DEPTH = sfbe_pkg::PROG_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire sfbe_pkg::insn_t wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output sfbe_pkg::insn_t      rdata
);

  sfbe_pkg::insn_t mem [DEPTH];
  sfbe_pkg::insn_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### sv/sfbe_core.sv
// Fetch and execute sequencer with the accumulator, program counter and record.
`default_nettype none
module sfbe_core #(
  parameter int PROG_DEPTH = sfbe_pkg::PROG_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_mode,
  input  wire logic [sfbe_pkg::SLOT_W-1:0]     in_slot,
  input  wire logic [63:0]                     in_instruction,
  input  wire logic [sfbe_pkg::REC_W-1:0]      in_record,
  input  wire logic [sfbe_pkg::PC_W-1:0]       limit,
  output logic                                 res_valid,
  input  wire logic                            res_ready,
  output logic [sfbe_pkg::WORD_W-1:0]          res_verdict
);

  localparam int AW = $clog2(PROG_DEPTH);

  sfbe_pkg::state_t state_r, state_nxt;

  logic [sfbe_pkg::PC_W-1:0]   pc_r, pc_nxt;
  logic [sfbe_pkg::WORD_W-1:0] acc_r, acc_nxt;
  logic [sfbe_pkg::WORD_W-1:0] verdict_r, verdict_nxt;
  logic [sfbe_pkg::REC_W-1:0]  rec_r, rec_nxt;

  sfbe_pkg::insn_t insn;
  logic            mem_we, mem_re;
  logic            accept, fetch_ok;
  logic            exec_fin, acc_ld, cond;
  logic [sfbe_pkg::WORD_W-1:0] exec_verdict, load_val;
  logic [sfbe_pkg::REC_W-1:0]  rec_shift;
  logic [7:0]                  jump_off;

  assign accept   = in_valid && in_ready;
  assign fetch_ok = pc_r < limit;

  sfbe_store #(.DEPTH(PROG_DEPTH), .AW(AW)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (AW'(in_slot)),
    .wdata (sfbe_pkg::insn_t'(in_instruction)),
    .re    (mem_re),
    .raddr (AW'(pc_r)),
    .rdata (insn)
  );

  // Instruction decode and execute.
  assign rec_shift = rec_r >> {insn.k[5:0], 3'b000};
  assign load_val  = rec_shift[sfbe_pkg::WORD_W-1:0];

  always_comb begin
    exec_fin     = 1'b0;
    exec_verdict = '0;
    acc_ld       = 1'b0;
    cond         = 1'b0;
    unique case (insn.opcode)
      sfbe_pkg::OP_LDW: begin
        if (insn.k > 32'(sfbe_pkg::LOAD_MAX)) begin
          exec_fin = 1'b1;
        end else begin
          acc_ld = 1'b1;
        end
      end
      sfbe_pkg::OP_JEQ:  cond = acc_r == insn.k;
      sfbe_pkg::OP_JGE:  cond = acc_r >= insn.k;
      sfbe_pkg::OP_JGT:  cond = acc_r > insn.k;
      sfbe_pkg::OP_JSET: cond = (acc_r & insn.k) != '0;
      sfbe_pkg::OP_RET: begin
        exec_fin     = 1'b1;
        exec_verdict = insn.k;
      end
      default: exec_fin = 1'b1;
    endcase
  end

  assign jump_off = acc_ld ? 8'd0 : (cond ? insn.jt : insn.jf);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sfbe_pkg::ST_IDLE:  if (accept && in_mode) state_nxt = sfbe_pkg::ST_FETCH;
      sfbe_pkg::ST_FETCH: state_nxt = fetch_ok ? sfbe_pkg::ST_EXEC : sfbe_pkg::ST_DONE;
      sfbe_pkg::ST_EXEC:  state_nxt = exec_fin ? sfbe_pkg::ST_DONE : sfbe_pkg::ST_FETCH;
      sfbe_pkg::ST_DONE:  if (res_ready) state_nxt = sfbe_pkg::ST_IDLE;
      default:            state_nxt = sfbe_pkg::ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    in_ready  = 1'b0;
    mem_re    = 1'b0;
    res_valid = 1'b0;
    unique case (state_r)
      sfbe_pkg::ST_IDLE:  in_ready  = 1'b1;
      sfbe_pkg::ST_FETCH: mem_re    = fetch_ok;
      sfbe_pkg::ST_EXEC:  ;
      sfbe_pkg::ST_DONE:  res_valid = 1'b1;
      default:            ;
    endcase
  end

  // Writes beyond the store depth are dropped.
  assign mem_we = accept && !in_mode && (32'(in_slot) < PROG_DEPTH);

  // Datapath next values.
  always_comb begin
    pc_nxt      = pc_r;
    acc_nxt     = acc_r;
    verdict_nxt = verdict_r;
    rec_nxt     = rec_r;
    unique case (state_r)
      sfbe_pkg::ST_IDLE: begin
        if (accept && in_mode) begin
          pc_nxt  = '0;
          acc_nxt = '0;
          rec_nxt = in_record;
        end
      end
      sfbe_pkg::ST_FETCH: begin
        if (!fetch_ok) begin
          verdict_nxt = '0;
        end
      end
      sfbe_pkg::ST_EXEC: begin
        if (exec_fin) begin
          verdict_nxt = exec_verdict;
        end else begin
          pc_nxt = pc_r + sfbe_pkg::PC_W'(1) + sfbe_pkg::PC_W'(jump_off);
          if (acc_ld) begin
            acc_nxt = load_val;
          end
        end
      end
      sfbe_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sfbe_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pc_r      <= pc_nxt;
    acc_r     <= acc_nxt;
    verdict_r <= verdict_nxt;
    rec_r     <= rec_nxt;
  end

  assign res_verdict = verdict_r;

endmodule
`default_nettype wire

### tb/tb_syscall_filter_bytecode_engine.sv
// Self-checking testbench for the syscall filter bytecode engine.
`timescale 1ns / 100ps

module tb_syscall_filter_bytecode_engine;

  // Transfer kinds on the request channel.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  // An opcode the engine does not know; any verdict it reaches must be zero.
  localparam logic [15:0] OP_BOGUS = 16'hffff;

  localparam int unsigned HOLD_CYCLES  = 300;
  // The longest run is a full store of 256 instructions.
  localparam int unsigned SETTLE_CYCLES = 600;
  localparam longint      RUN_LIMIT_NS  = 64'd50_000_000;

  // One request as it is offered on the in_ channel. Write transfers carry
  // random record contents and evaluate transfers random slot and instruction
  // bits, so every payload bit toggles whatever the mode.
  typedef struct packed {
    logic             mode;
    logic [7:0]       slot;
    logic [63:0]      insn;
    logic [31:0]      nr;
    logic [31:0]      arch;
    logic [5:0][63:0] args;
  } filter_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = MODE_WRITE;
  logic [7:0]  in_slot = '0;
  logic [63:0] in_instruction = '0;
  logic [31:0] in_syscall_number = '0;
  logic [31:0] in_arch_id = '0;
  logic [63:0] in_arg0 = '0;
  logic [63:0] in_arg1 = '0;
  logic [63:0] in_arg2 = '0;
  logic [63:0] in_arg3 = '0;
  logic [63:0] in_arg4 = '0;
  logic [63:0] in_arg5 = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_verdict;
  logic        cfg_we = 1'b0;
  logic [8:0]  cfg_wdata = '0;

  // Predictor state: our own copy of the program store and the length register.
  sfbe_pkg::insn_t prog_mem [sfbe_pkg::PROG_DEPTH_DEF];
  int unsigned     prog_len = 0;

  filter_req_t req_backlog [$];
  filter_req_t offered_req;
  logic [31:0] verdicts_due [$];
  int unsigned reqs_in_flight = 0;
  int unsigned error_count = 0;

  // Idling controls: the idle and stall rates are set by the stimulus process between phases.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;

  // Values shared between programs and records of one phase, so that the
  // equality and range tests actually go both ways.
  logic [31:0] word_pool [8];

  syscall_filter_bytecode_engine u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_mode           (in_mode),
    .in_slot           (in_slot),
    .in_instruction    (in_instruction),
    .in_syscall_number (in_syscall_number),
    .in_arch_id        (in_arch_id),
    .in_arg0           (in_arg0),
    .in_arg1           (in_arg1),
    .in_arg2           (in_arg2),
    .in_arg3           (in_arg3),
    .in_arg4           (in_arg4),
    .in_arg5           (in_arg5),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_verdict       (out_verdict),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  // Runs the stored program over one record, laid out little-endian in a
  // 512-bit vector so that a word load is a plain part select at 8*offset.
  function automatic logic [31:0] filter_verdict(input filter_req_t r);
    logic [511:0]    rec;
    logic [31:0]     acc;
    sfbe_pkg::insn_t ins;
    int unsigned     pc;
    int unsigned     limit;
    int unsigned     offs;
    rec   = {r.args, 64'd0, r.arch, r.nr};
    acc   = '0;
    pc    = 0;
    limit = (prog_len > sfbe_pkg::PROG_DEPTH_DEF) ? sfbe_pkg::PROG_DEPTH_DEF : prog_len;
    while (pc < limit) begin
      ins = prog_mem[pc];
      case (ins.opcode)
        sfbe_pkg::OP_LDW: begin
          if (ins.k > sfbe_pkg::LOAD_MAX) return '0;
          offs = ins.k;
          acc  = rec[offs*8 +: 32];
          pc   = pc + 1;
        end
        sfbe_pkg::OP_JEQ:  pc = pc + 1 + ((acc == ins.k) ? ins.jt : ins.jf);
        sfbe_pkg::OP_JGE:  pc = pc + 1 + ((acc >= ins.k) ? ins.jt : ins.jf);
        sfbe_pkg::OP_JGT:  pc = pc + 1 + ((acc > ins.k) ? ins.jt : ins.jf);
        sfbe_pkg::OP_JSET: pc = pc + 1 + (((acc & ins.k) != 0) ? ins.jt : ins.jf);
        sfbe_pkg::OP_RET:  return ins.k;
        default: return '0;
      endcase
    end
    // Fell or jumped off the end of the program.
    return '0;
  endfunction

  // Request driver. An accepted write updates the shadow store at once, so a
  // following evaluate sees it in transfer order; an accepted evaluate queues
  // its predicted verdict.
  always @(posedge clk) begin : drive_requests
    logic give;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (offered_req.mode == MODE_WRITE) begin
          prog_mem[offered_req.slot] = offered_req.insn;
        end else begin
          verdicts_due = {verdicts_due, filter_verdict(offered_req)};
        end
        reqs_in_flight--;
      end
      if (!in_valid || in_ready) begin
        give = (req_backlog.size() != 0) && ($urandom_range(1, 100) > send_idle_pct);
        if (give) begin
          offered_req = req_backlog.pop_front();
          in_mode           <= offered_req.mode;
          in_slot           <= offered_req.slot;
          in_instruction    <= offered_req.insn;
          in_syscall_number <= offered_req.nr;
          in_arch_id        <= offered_req.arch;
          in_arg0           <= offered_req.args[0];
          in_arg1           <= offered_req.args[1];
          in_arg2           <= offered_req.args[2];
          in_arg3           <= offered_req.args[3];
          in_arg4           <= offered_req.args[4];
          in_arg5           <= offered_req.args[5];
        end
        in_valid <= give;
      end
    end
  end

  // Long receiver hold-off, counted here so that it runs on regardless of
  // what the stimulus process is doing.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_req) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Verdict monitor: every transfer on out_ must match the oldest prediction.
  always @(posedge clk) begin : check_verdicts
    logic [31:0] want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          flag_error($sformatf("verdict %h with no evaluate outstanding", out_verdict));
        end else begin
          want = verdicts_due.pop_front();
          if (out_verdict !== want) begin
            flag_error($sformatf("verdict %h, expected %h", out_verdict, want));
          end
        end
      end
      out_ready <= (hold_left == 0) && ($urandom_range(1, 100) > recv_stall_pct);
    end
  end

  function automatic sfbe_pkg::insn_t encode(input logic [15:0] op, input logic [7:0] jt,
                                             input logic [7:0] jf, input logic [31:0] k);
    sfbe_pkg::insn_t ins;
    ins.opcode = op;
    ins.jt     = jt;
    ins.jf     = jf;
    ins.k      = k;
    return ins;
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:          return '0;
      1:          return '1;
      2, 3, 4, 5: return word_pool[$urandom_range(0, 7)];
      default:    return $urandom;
    endcase
  endfunction

  // Mostly offsets of whole fields, some unaligned ones, and now and then an
  // offset past the last whole word of the record.
  function automatic logic [31:0] load_offset();
    case ($urandom_range(0, 9))
      0:       return $urandom_range(sfbe_pkg::LOAD_MAX + 1, 32'hffff_ffff);
      1, 2:    return $urandom_range(0, sfbe_pkg::LOAD_MAX);
      default: return 4 * $urandom_range(0, 15);
    endcase
  endfunction

  function automatic logic [7:0] jump_offset();
    if ($urandom_range(0, 4) == 0) return 8'($urandom);
    return 8'($urandom_range(0, 3));
  endfunction

  // A filter-like instruction. Long programs get few returns so that runs go
  // deep; the last instruction of a program is usually a return.
  function automatic sfbe_pkg::insn_t random_insn(input bit last, input bit long_prog);
    sfbe_pkg::insn_t ins;
    int unsigned     pick;
    ins  = encode(sfbe_pkg::OP_RET, jump_offset(), jump_offset(), $urandom);
    pick = $urandom_range(0, 99);
    if (last ? (pick < 70) : (pick < (long_prog ? 3 : 20))) return ins;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      ins.opcode = sfbe_pkg::OP_LDW;
      ins.k      = load_offset();
    end else if (pick < 60) begin
      ins.opcode = sfbe_pkg::OP_JEQ;
      ins.k      = pick_word();
    end else if (pick < 72) begin
      ins.opcode = sfbe_pkg::OP_JGE;
      ins.k      = pick_word();
    end else if (pick < 84) begin
      ins.opcode = sfbe_pkg::OP_JGT;
      ins.k      = pick_word();
    end else if (pick < 96) begin
      ins.opcode = sfbe_pkg::OP_JSET;
      ins.k      = ($urandom_range(0, 1) == 0) ? (32'd1 << $urandom_range(0, 31)) : pick_word();
    end else begin
      ins.opcode = 16'($urandom);
    end
    return ins;
  endfunction

  function automatic filter_req_t random_eval();
    filter_req_t r;
    r.mode = MODE_EVAL;
    r.slot = 8'($urandom);
    r.insn = {$urandom, $urandom};
    r.nr   = pick_word();
    r.arch = pick_word();
    for (int i = 0; i < 6; i++) begin
      r.args[i] = {pick_word(), pick_word()};
    end
    return r;
  endfunction

  task automatic push_req(input filter_req_t r);
    req_backlog = {req_backlog, r};
    reqs_in_flight++;
  endtask

  task automatic push_write(input logic [7:0] slot, input sfbe_pkg::insn_t ins);
    filter_req_t r;
    r      = random_eval();
    r.mode = MODE_WRITE;
    r.slot = slot;
    r.insn = ins;
    push_req(r);
  endtask

  task automatic push_directed_eval(input logic [31:0] nr, input logic [31:0] arg5_hi);
    filter_req_t r;
    r                = random_eval();
    r.nr             = nr;
    r.args[5][63:32] = arg5_hi;
    push_req(r);
  endtask

  // Waits until every request is taken and every verdict is back, then gives
  // a trailing write time to land before the register is touched.
  task automatic wait_drain();
    while (reqs_in_flight != 0 || verdicts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_program_length(input int unsigned len);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= len[8:0];
    prog_len   = len;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin : stimulus
    int unsigned cfg;
    int unsigned n_insn;
    int unsigned n_eval;
    bit          long_prog;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // With the length still at its reset value of zero the program is empty,
    // so an evaluate overruns at once without reading the store.
    push_req(random_eval());
    wait_drain();

    // Directed program; the syscall number picks the path:
    //   1: load past the record end, 2: unknown opcode, below 10: jump past
    //   the end, 10..20: return (both range tests on their boundary),
    //   above 20 with the top bit set: far jump past the end, otherwise a load
    //   of the last word of the record picks one of two returns.
    push_write(8'd0,  encode(sfbe_pkg::OP_LDW,  8'd0,  8'd0, 32'd0));
    push_write(8'd1,  encode(sfbe_pkg::OP_JEQ,  8'd0,  8'd1, 32'd1));
    push_write(8'd2,  encode(sfbe_pkg::OP_LDW,  8'd0,  8'd0, sfbe_pkg::LOAD_MAX + 1));
    push_write(8'd3,  encode(sfbe_pkg::OP_JEQ,  8'd8,  8'd0, 32'd2));
    push_write(8'd4,  encode(sfbe_pkg::OP_JGE,  8'd0,  8'd8, 32'd10));
    push_write(8'd5,  encode(sfbe_pkg::OP_JGT,  8'd1,  8'd0, 32'd20));
    push_write(8'd6,  encode(sfbe_pkg::OP_RET,  8'd0,  8'd0, 32'h7fff_0000));
    push_write(8'd7,  encode(sfbe_pkg::OP_JSET, 8'hff, 8'd0, 32'h8000_0000));
    push_write(8'd8,  encode(sfbe_pkg::OP_LDW,  8'd0,  8'd0, sfbe_pkg::LOAD_MAX));
    push_write(8'd9,  encode(sfbe_pkg::OP_JSET, 8'd1,  8'd0, 32'hffff_ffff));
    push_write(8'd10, encode(sfbe_pkg::OP_RET,  8'd0,  8'd0, 32'hffff_ffff));
    push_write(8'd11, encode(sfbe_pkg::OP_RET,  8'd0,  8'd0, 32'h0005_0001));
    push_write(8'd12, encode(OP_BOGUS, 8'hff, 8'hff, 32'hffff_ffff));
    wait_drain();
    set_program_length(13);
    push_directed_eval(32'd1,         32'd0);
    push_directed_eval(32'd2,         32'd0);
    push_directed_eval(32'd0,         32'd0);
    push_directed_eval(32'd5,         32'd0);
    push_directed_eval(32'd10,        32'd0);
    push_directed_eval(32'd20,        32'd0);
    push_directed_eval(32'd21,        32'd0);
    push_directed_eval(32'd21,        32'h8000_0001);
    push_directed_eval(32'hffff_ffff, 32'hffff_ffff);
    wait_drain();

    // Random phases. The first fills the whole store, so that every later
    // length, up to the full depth, only ever reaches written entries.
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      for (int i = 0; i < 8; i++) word_pool[i] = $urandom;

      case (p)
        0, 4:    cfg = sfbe_pkg::PROG_DEPTH_DEF;
        1:       cfg = 1;
        3:       cfg = 0;
        6:       cfg = $urandom_range(25, sfbe_pkg::PROG_DEPTH_DEF - 1);
        default: cfg = $urandom_range(2, 24);
      endcase
      long_prog = (cfg > 24);
      if (p == 0) begin
        n_insn = sfbe_pkg::PROG_DEPTH_DEF;
      end else if (cfg >= 1 && cfg <= 24) begin
        n_insn = cfg;
      end else begin
        // Short rewrite at the head; a long length runs on into older code.
        n_insn = $urandom_range(3, 16);
      end
      for (int i = 0; i < n_insn; i++) begin
        push_write(8'(i), random_insn(i == n_insn - 1, long_prog));
      end
      wait_drain();
      set_program_length(cfg);

      n_eval = long_prog ? 35 : ((cfg == 0) ? 20 : 45);
      for (int i = 0; i < n_eval; i++) begin
        // Occasional rewrites land between evaluates of the same program.
        if ($urandom_range(0, 9) == 0) begin
          push_write(8'($urandom), random_insn(1'b0, long_prog));
        end
        push_req(random_eval());
      end
      if (p == 4) begin
        // Keep out_ready low while the sender offers at full rate, so that the
        // verdict register and the sequencer fill and the input backs up.
        @(posedge clk);
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      wait_drain();
    end

    // Anything arriving now has no prediction and is caught by the monitor.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("status: fail");
    $finish;
  end

endmodule

### syscall_filter_bytecode_engine.f
sv/sfbe_pkg.sv
sv/sfbe_store.sv
sv/sfbe_core.sv
sv/syscall_filter_bytecode_engine.sv
tb/tb_syscall_filter_bytecode_engine.sv
